// ----- hw/rtl/acia_pkg.sv -----
package acia_pkg;

  // item mode codes
  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  // register addresses
  localparam logic [1:0] REG_DATA    = 2'd0;
  localparam logic [1:0] REG_STATUS  = 2'd1;
  localparam logic [1:0] REG_COMMAND = 2'd2;
  localparam logic [1:0] REG_CONTROL = 2'd3;

  // status bit positions
  localparam int unsigned ST_IRQ  = 7;
  localparam int unsigned ST_TDRE = 4;
  localparam int unsigned ST_RDRF = 3;
  localparam int unsigned ST_OVRN = 2;

  // command bit positions and fields
  localparam int unsigned CMD_REM = 4;
  localparam int unsigned CMD_IRD = 1;
  localparam logic [1:0] TIC_TX_IRQ = 2'b01;
  localparam logic [7:0] CMD_KEEP   = 8'hE0;

  localparam logic [7:0] STATUS_RESET = 8'h10;

  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] reg_select;
    logic [7:0] write_data;
    logic       rx_present;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq;
    logic       rx_accepted;
    logic       echo_valid;
    logic [7:0] echo_byte;
    logic       tx_valid;
    logic [7:0] tx_byte;
  } result_t;

endpackage

// ----- hw/rtl/acia_core.sv -----
module acia_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fire,
  input  acia_pkg::item_t item,
  output acia_pkg::result_t res
);

  logic [7:0] transmit_hold_r, transmit_hold_nxt;
  logic [7:0] receive_hold_r, receive_hold_nxt;
  logic [7:0] command_r, command_nxt;
  logic [7:0] control_r, control_nxt;
  logic [7:0] status_r, status_nxt;
  logic       tx_pending_r, tx_pending_nxt;

  always_comb begin
    transmit_hold_nxt = transmit_hold_r;
    receive_hold_nxt  = receive_hold_r;
    command_nxt       = command_r;
    control_nxt       = control_r;
    status_nxt        = status_r;
    tx_pending_nxt    = tx_pending_r;
    res               = '0;
    case (item.mode)
      acia_pkg::MODE_READ: begin
        case (item.reg_select)
          acia_pkg::REG_DATA: begin
            res.read_data = receive_hold_r;
            status_nxt[acia_pkg::ST_IRQ]  = 1'b0;
            status_nxt[acia_pkg::ST_RDRF] = 1'b0;
          end
          acia_pkg::REG_STATUS: begin
            res.read_data = status_r;
            status_nxt[acia_pkg::ST_IRQ] = 1'b0;
          end
          acia_pkg::REG_COMMAND: res.read_data = command_r;
          default:               res.read_data = control_r;
        endcase
      end
      acia_pkg::MODE_WRITE: begin
        case (item.reg_select)
          acia_pkg::REG_DATA: begin
            transmit_hold_nxt = item.write_data;
            status_nxt[acia_pkg::ST_TDRE] = 1'b0;
            tx_pending_nxt = 1'b1;
          end
          acia_pkg::REG_STATUS: begin
            // programmed reset
            command_nxt = command_r & acia_pkg::CMD_KEEP;
            status_nxt[acia_pkg::ST_OVRN] = 1'b0;
          end
          acia_pkg::REG_COMMAND: command_nxt = item.write_data;
          default:               control_nxt = item.write_data;
        endcase
      end
      acia_pkg::MODE_TICK: begin
        if (item.rx_present) begin
          if (status_r[acia_pkg::ST_RDRF]) begin
            status_nxt[acia_pkg::ST_OVRN] = 1'b1;
          end else begin
            receive_hold_nxt = item.rx_byte;
            status_nxt[acia_pkg::ST_RDRF] = 1'b1;
            res.rx_accepted = 1'b1;
            if (command_r[acia_pkg::CMD_REM]) begin
              res.echo_valid = 1'b1;
              res.echo_byte  = item.rx_byte;
            end
            if (!command_r[acia_pkg::CMD_IRD]) status_nxt[acia_pkg::ST_IRQ] = 1'b1;
          end
        end
        if (tx_pending_r) begin
          res.tx_valid = 1'b1;
          res.tx_byte  = transmit_hold_r;
          status_nxt[acia_pkg::ST_TDRE] = 1'b1;
          tx_pending_nxt = 1'b0;
          if (!command_r[acia_pkg::CMD_IRD] && command_r[3:2] == acia_pkg::TIC_TX_IRQ)
            status_nxt[acia_pkg::ST_IRQ] = 1'b1;
        end
      end
      default: ;
    endcase
    res.irq = status_nxt[acia_pkg::ST_IRQ];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      transmit_hold_r <= '0;
      receive_hold_r  <= '0;
      command_r       <= '0;
      control_r       <= '0;
      status_r        <= acia_pkg::STATUS_RESET;
      tx_pending_r    <= 1'b0;
    end else if (fire) begin
      transmit_hold_r <= transmit_hold_nxt;
      receive_hold_r  <= receive_hold_nxt;
      command_r       <= command_nxt;
      control_r       <= control_nxt;
      status_r        <= status_nxt;
      tx_pending_r    <= tx_pending_nxt;
    end
  end

  // a pending transmit byte and an empty transmitter never coexist
  a_pending_tdre: assert property (@(posedge clk) disable iff (!rst_n)
    tx_pending_r == !status_r[acia_pkg::ST_TDRE])
    else $error("transmit pending disagrees with TDRE");

  a_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.mode == acia_pkg::MODE_TICK && item.rx_present &&
    status_r[acia_pkg::ST_RDRF] |=> status_r[acia_pkg::ST_OVRN] && !res.rx_accepted)
    else $error("full receiver did not flag overrun");

  a_tx_drain: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.tx_valid |=> !tx_pending_r)
    else $error("transmit byte still pending after send");

  a_echo_rx: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.echo_valid |-> res.rx_accepted && item.mode == acia_pkg::MODE_TICK)
    else $error("echo without an accepted byte");

endmodule

// ----- hw/rtl/acia_serial_register_block.sv -----
// simplified 6551-style acia with four byte registers
// input channel: one item per transfer, either a bus read, a bus write or a
// tick (mode), with the register address, write byte and the byte offered by
// the serial link; output channel: one result per item with the read byte,
// the irq bit, the receive flag and any echo or transmit byte for the link
// the item is registered on entry, then the register state is updated and the
// result registered when the item advances, and out_valid rises with the result;
// one item per cycle sustained while the receiver does not stall
// reset clears the data, command and control registers, status reads 0x10
// (transmitter empty), no item or result is held
// when the receiver stalls, the result register holds its value; one more
// item may wait in the input register, after which in_stall is raised
module acia_serial_register_block (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_mode,
  input  logic [1:0] in_reg_select,
  input  logic [7:0] in_write_data,
  input  logic       in_rx_present,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_read_data,
  output logic       out_irq,
  output logic       out_rx_accepted,
  output logic       out_echo_valid,
  output logic [7:0] out_echo_byte,
  output logic       out_tx_valid,
  output logic [7:0] out_tx_byte
);

  acia_pkg::item_t   item_r;
  acia_pkg::result_t res, res_r;
  logic              item_valid_r;
  logic              out_valid_r;
  logic              advance;

  assign advance  = item_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = item_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (!in_stall) item_valid_r <= in_valid;
      if (advance) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r.mode       <= in_mode;
      item_r.reg_select <= in_reg_select;
      item_r.write_data <= in_write_data;
      item_r.rx_present <= in_rx_present;
      item_r.rx_byte    <= in_rx_byte;
    end
    if (advance) res_r <= res;
  end

  acia_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .item  (item_r),
    .res   (res)
  );

  assign out_valid       = out_valid_r;
  assign out_read_data   = res_r.read_data;
  assign out_irq         = res_r.irq;
  assign out_rx_accepted = res_r.rx_accepted;
  assign out_echo_valid  = res_r.echo_valid;
  assign out_echo_byte   = res_r.echo_byte;
  assign out_tx_valid    = res_r.tx_valid;
  assign out_tx_byte     = res_r.tx_byte;

endmodule
